// ===== rtl/ssp_pkg.sv =====
package ssp_pkg;

  // Output kinds carried on tuser
  localparam logic KIND_PARAM = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Header and id-abort marker byte
  localparam logic [7:0] MARK_BYTE = 8'hFF;

  // Minimum length: id length counts error byte and checksum
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  // Byte held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } ssp_byte_t;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] param_value;
    logic [7:0] param_index;
    logic [7:0] servo_id;
    logic [7:0] error_flags;
    logic       checksum_ok;
  } ssp_result_t;

endpackage

// ===== rtl/servo_status_packet_parser.sv =====
// Servo status packet parser.
// Slave channel: one received serial byte per transfer on s_tdata.
// Master channel: zero or one result per byte. tuser is the kind: 0 for a
// parameter byte (value and index in tdata), 1 for end of packet (id, error
// byte and checksum flag in tdata). After a failed checksum the receiver
// should drop the parameters already delivered for that packet.
// A byte in the input register is parsed into the result register, which
// drives m_tvalid, once the result register can take a new item.
// Throughput: one byte per cycle unless a held result waits on m_tready,
// set by the phase update and 8-bit running sum in the parser; header, id,
// length and error bytes produce no transfer on the master side.
// Reset (rst, synchronous) empties both registers and returns the parser to
// hunting for the first header byte.
// When m_tvalid is high and m_tready is low the result register holds and the input register
// keeps one byte; s_tready then drops until the result is taken.
module servo_status_packet_parser
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] param_value, [15:8] param_index,
                                 // [23:16] servo_id, [31:24] error_flags,
                                 // [32] checksum_ok, [39:33] zero
  output logic        m_tuser    // [0] kind
);

  ssp_byte_t   held;
  logic        take;
  ssp_result_t result;

  ssp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .held     (held)
  );

  ssp_parser u_parse (
    .clk      (clk),
    .rst      (rst),
    .held     (held),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .result   (result)
  );

  // Pack result fields, highest field first
  assign m_tdata = {7'd0, result.checksum_ok, result.error_flags, result.servo_id,
                    result.param_index, result.param_value};
  assign m_tuser = result.kind;

endmodule

// ===== rtl/ssp_in_stage.sv =====
module ssp_in_stage
  import ssp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       take,
  output ssp_byte_t  held
);

  ssp_byte_t held_next;

  // Free when empty or when the parser consumes the held byte this cycle
  assign s_tready = !held.valid || take;

  always_comb begin
    held_next = held;
    if (s_tready) begin
      held_next.valid = s_tvalid;
      if (s_tvalid) begin
        held_next.data = s_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
      held.data  <= '0;
    end else begin
      held <= held_next;
    end
  end

endmodule

// ===== rtl/ssp_parser.sv =====
module ssp_parser
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ssp_byte_t   held,
  output logic        take,
  output logic        m_tvalid,
  input  logic        m_tready,
  output ssp_result_t result
);

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_ID,
    PH_LEN,
    PH_ERR,
    PH_PARAM,
    PH_SUM
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  held_id, held_id_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  held_error, held_error_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  params_seen, params_seen_next;
  logic        emit;
  ssp_result_t result_next;
  logic [7:0]  b;
  logic [7:0]  sum_add;
  logic [8:0]  seen_plus_two;

  // Consume the held byte whenever the result register can take a new item
  assign take = held.valid && (!m_tvalid || m_tready);
  assign b    = held.data;

  assign sum_add       = running_sum + b;
  assign seen_plus_two = {1'b0, params_seen_next} + {1'b0, MIN_LENGTH};

  // Per-byte phase update and result formation
  always_comb begin
    phase_next       = phase;
    held_id_next     = held_id;
    held_length_next = held_length;
    held_error_next  = held_error;
    running_sum_next = running_sum;
    params_seen_next = params_seen;
    emit             = 1'b0;
    result_next      = '0;
    case (phase)
      PH_HUNT2: begin
        phase_next = (b == MARK_BYTE) ? PH_ID : PH_HUNT1;
      end
      PH_ID: begin
        if (b == MARK_BYTE) begin
          phase_next = PH_HUNT1;
        end else begin
          held_id_next     = b;
          running_sum_next = b;
          phase_next       = PH_LEN;
        end
      end
      PH_LEN: begin
        held_length_next = b;
        running_sum_next = sum_add;
        phase_next       = PH_ERR;
      end
      PH_ERR: begin
        held_error_next  = b;
        running_sum_next = sum_add;
        params_seen_next = '0;
        phase_next       = (held_length <= MIN_LENGTH) ? PH_SUM : PH_PARAM;
      end
      PH_PARAM: begin
        emit                    = 1'b1;
        result_next.kind        = KIND_PARAM;
        result_next.param_value = b;
        result_next.param_index = params_seen;
        running_sum_next        = sum_add;
        params_seen_next        = params_seen + 8'd1;
        if (seen_plus_two == {1'b0, held_length}) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        emit                    = 1'b1;
        result_next.kind        = KIND_END;
        result_next.servo_id    = held_id;
        result_next.error_flags = held_error;
        result_next.checksum_ok = (sum_add == MARK_BYTE);
        phase_next              = PH_HUNT1;
      end
      default: begin
        phase_next = (b == MARK_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  // Parse state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT1;
      held_id     <= '0;
      held_length <= '0;
      held_error  <= '0;
      running_sum <= '0;
      params_seen <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (take) begin
        phase       <= phase_next;
        held_id     <= held_id_next;
        held_length <= held_length_next;
        held_error  <= held_error_next;
        running_sum <= running_sum_next;
        params_seen <= params_seen_next;
        if (emit) begin
          m_tvalid <= 1'b1;
          result   <= result_next;
        end
      end
    end
  end

endmodule
